// File: src/circular_list_rotate_count_core_macros.svh
// Assertion macros used by the checker file.
`ifndef CIRCULAR_LIST_ROTATE_COUNT_CORE_MACROS_SVH
`define CIRCULAR_LIST_ROTATE_COUNT_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CLRC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("clrc assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define CLRC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("clrc assertion failed");

`endif

// File: src/clrc_pkg.sv
// Shared constants and types for the circular list core.
`timescale 1ns / 1ps
package clrc_pkg;

	localparam int CMD_W     = 3;
	localparam int ERR_W     = 2;
	localparam int CNT_OUT_W = 7;

	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ROTATE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd4;

	localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
	localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

	typedef struct packed {
		logic [CNT_OUT_W-1:0] match_count;
		logic [CNT_OUT_W-1:0] entry_count;
		logic [ERR_W-1:0]     error_code;
	} res_stat_t;

endpackage

// File: src/clrc_ram.sv
// Single-port ring store with synchronous (registered) read.
`timescale 1ns / 1ps
module clrc_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// File: src/clrc_ctrl.sv
// Command sequencer: front pointer, length, cached front entry and count walk.
`timescale 1ns / 1ps
module clrc_ctrl #(
	parameter int CAPACITY    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [clrc_pkg::CMD_W-1:0]    command,
	input  logic [VALUE_WIDTH-1:0]        operand_value,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [VALUE_WIDTH-1:0]        res_front,
	output clrc_pkg::res_stat_t           res_stat,
	output logic                          mem_we,
	output logic                          mem_re,
	output logic [$clog2(CAPACITY)-1:0]   mem_addr,
	output logic [VALUE_WIDTH-1:0]        mem_wdata,
	input  logic [VALUE_WIDTH-1:0]        mem_rdata
);

	localparam int PW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = CW + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_ROTR = 3'd2;
	localparam logic [2:0] ST_RDW  = 3'd3;
	localparam logic [2:0] ST_CNT  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
		ring_next = (p == PW'(CAPACITY - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] p);
		ring_prev = (p == '0) ? PW'(CAPACITY - 1) : p - 1'b1;
	endfunction

	function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] p, input logic [CW-1:0] n);
		logic [SW-1:0] s;
		s = SW'(p) + SW'(n);
		ring_add = (s >= SW'(CAPACITY)) ? PW'(s - SW'(CAPACITY)) : PW'(s);
	endfunction

	logic [2:0]                     state_q;
	logic [clrc_pkg::CMD_W-1:0]     cmd_q;
	logic [VALUE_WIDTH-1:0]         val_q;
	logic [VALUE_WIDTH-1:0]         fv_q;
	logic [PW-1:0]                  front_q;
	logic [PW-1:0]                  ptr_q;
	logic [CW-1:0]                  cnt_q;
	logic [CW-1:0]                  issued_q;
	logic [CW-1:0]                  matches_q;
	logic [clrc_pkg::ERR_W-1:0]     err_q;
	logic                           rd_pend_s1;

	logic full;
	logic empty;
	logic walk_more;

	assign full      = (cnt_q == CW'(CAPACITY));
	assign empty     = (cnt_q == '0);
	assign walk_more = (issued_q != cnt_q);

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res_front = empty ? '0 : fv_q;
	assign res_stat.match_count = clrc_pkg::CNT_OUT_W'(matches_q);
	assign res_stat.entry_count = clrc_pkg::CNT_OUT_W'(cnt_q);
	assign res_stat.error_code  = err_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = front_q;
		mem_wdata = val_q;
		case (state_q)
			ST_EXEC: begin
				case (cmd_q)
					clrc_pkg::CMD_INSERT: begin
						if (!full) begin
							mem_we   = 1'b1;
							mem_addr = ring_prev(front_q);
						end
					end
					clrc_pkg::CMD_DELETE: begin
						if (cnt_q > CW'(1)) begin
							mem_re   = 1'b1;
							mem_addr = ring_next(front_q);
						end
					end
					clrc_pkg::CMD_ROTATE: begin
						// old front goes to the slot past the tail
						if (!empty) begin
							mem_we    = 1'b1;
							mem_addr  = ring_add(front_q, cnt_q);
							mem_wdata = fv_q;
						end
					end
					default: ;
				endcase
			end
			ST_ROTR: begin
				mem_re = 1'b1;
			end
			ST_CNT: begin
				mem_re   = walk_more;
				mem_addr = ptr_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			front_q    <= '0;
			cnt_q      <= '0;
			issued_q   <= '0;
			matches_q  <= '0;
			err_q      <= clrc_pkg::ERR_OK;
			rd_pend_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q     <= command;
						val_q     <= operand_value;
						matches_q <= '0;
						err_q     <= clrc_pkg::ERR_OK;
						state_q   <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_DONE;
					case (cmd_q)
						clrc_pkg::CMD_INSERT: begin
							if (full) begin
								err_q <= clrc_pkg::ERR_FULL;
							end else begin
								front_q <= ring_prev(front_q);
								cnt_q   <= cnt_q + 1'b1;
								fv_q    <= val_q;
							end
						end
						clrc_pkg::CMD_DELETE: begin
							if (empty) begin
								err_q <= clrc_pkg::ERR_EMPTY;
							end else begin
								front_q <= ring_next(front_q);
								cnt_q   <= cnt_q - 1'b1;
								if (cnt_q > CW'(1)) begin
									state_q <= ST_RDW;
								end
							end
						end
						clrc_pkg::CMD_ROTATE: begin
							// single entry: front value unchanged, no refetch
							if (!empty) begin
								front_q <= ring_next(front_q);
								if (cnt_q != CW'(1)) begin
									state_q <= ST_ROTR;
								end
							end
						end
						clrc_pkg::CMD_PEEK: begin
							if (empty) begin
								err_q <= clrc_pkg::ERR_EMPTY;
							end
						end
						clrc_pkg::CMD_COUNT: begin
							ptr_q    <= front_q;
							issued_q <= '0;
							if (!empty) begin
								state_q <= ST_CNT;
							end
						end
						default: ;
					endcase
				end
				ST_ROTR: begin
					state_q <= ST_RDW;
				end
				ST_RDW: begin
					fv_q    <= mem_rdata;
					state_q <= ST_DONE;
				end
				ST_CNT: begin
					rd_pend_s1 <= walk_more;
					if (walk_more) begin
						ptr_q    <= ring_next(ptr_q);
						issued_q <= issued_q + 1'b1;
					end
					if (rd_pend_s1 && (mem_rdata == val_q)) begin
						matches_q <= matches_q + 1'b1;
					end
					if (!walk_more && !rd_pend_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: src/circular_list_rotate_count_core.sv
// Insert, peek, no-op, error and one-entry commands finish straight from the execute state;
// delete passes through the read-wait state and rotate through the rotate-read and read-wait
// states, as both refetch the new front from the ring store. Count walks the N stored entries
// through the single memory port. One command in flight; the next beat is taken while a
// result waits in the output register.
// arst_n clears the list to empty (front pointer 0, length 0); store not cleared.
`timescale 1ns / 1ps
module circular_list_rotate_count_core #(
	parameter int CAPACITY    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [clrc_pkg::CMD_W-1:0]       command,
	input  logic signed [VALUE_WIDTH-1:0]    operand_value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [VALUE_WIDTH-1:0]    front_value,
	output logic [clrc_pkg::CNT_OUT_W-1:0]   match_count,
	output logic [clrc_pkg::CNT_OUT_W-1:0]   entry_count,
	output logic [clrc_pkg::ERR_W-1:0]       error_code
);

	localparam int PW = $clog2(CAPACITY);

	logic                      res_valid;
	logic                      res_ready;
	logic [VALUE_WIDTH-1:0]    res_front;
	clrc_pkg::res_stat_t       res_stat;
	logic                      mem_we;
	logic                      mem_re;
	logic [PW-1:0]             mem_addr;
	logic [VALUE_WIDTH-1:0]    mem_wdata;
	logic [VALUE_WIDTH-1:0]    mem_rdata;

	logic                      out_valid_q;
	logic [VALUE_WIDTH-1:0]    front_q;
	clrc_pkg::res_stat_t       stat_q;

	clrc_ctrl #(
		.CAPACITY   (CAPACITY),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.operand_value(operand_value),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res_front    (res_front),
		.res_stat     (res_stat),
		.mem_we       (mem_we),
		.mem_re       (mem_re),
		.mem_addr     (mem_addr),
		.mem_wdata    (mem_wdata),
		.mem_rdata    (mem_rdata)
	);

	clrc_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(VALUE_WIDTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.re   (mem_re),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// output register decouples the result beat from the sequencer
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			front_q <= res_front;
			stat_q  <= res_stat;
		end
	end

	assign out_valid   = out_valid_q;
	assign front_value = front_q;
	assign match_count = stat_q.match_count;
	assign entry_count = stat_q.entry_count;
	assign error_code  = stat_q.error_code;

endmodule

// File: src/clrc_chk.sv
// Port-level checker for the circular list core, bound to the top level.
`timescale 1ns / 1ps
`include "circular_list_rotate_count_core_macros.svh"
module clrc_chk #(
	parameter int CAPACITY    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic [clrc_pkg::CMD_W-1:0]       command,
	input logic signed [VALUE_WIDTH-1:0]    operand_value,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [VALUE_WIDTH-1:0]    front_value,
	input logic [clrc_pkg::CNT_OUT_W-1:0]   match_count,
	input logic [clrc_pkg::CNT_OUT_W-1:0]   entry_count,
	input logic [clrc_pkg::ERR_W-1:0]       error_code
);

	// a stalled result beat holds
	`CLRC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(front_value) && $stable(match_count) && $stable(entry_count) && $stable(error_code))
	// one command in flight: no input beat right after one is taken
	`CLRC_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
	// empty error only on an empty list, which reports a zero front
	`CLRC_ASSERT_NOW(a_empty_err, out_valid && (error_code == clrc_pkg::ERR_EMPTY), (entry_count == '0) && (front_value == '0) && (match_count == '0))
	// full error only with the list at capacity
	`CLRC_ASSERT_NOW(a_full_err, out_valid && (error_code == clrc_pkg::ERR_FULL), (entry_count == clrc_pkg::CNT_OUT_W'(CAPACITY)) && (match_count == '0))

endmodule

bind circular_list_rotate_count_core clrc_chk #(
	.CAPACITY   (CAPACITY),
	.VALUE_WIDTH(VALUE_WIDTH)
) u_clrc_chk (.*);
